@@ rtl/ascii_crc_frame_checker_unit_defines.svh @@
// Assertion macros used by the frame checker's port-level assertion module.
`ifndef ASCII_CRC_FRAME_CHECKER_UNIT_DEFINES_SVH
`define ASCII_CRC_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while dis is high.
`define ACFC_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("acfc: same-cycle check failed");

// Next-cycle implication, switched off while dis is high.
`define ACFC_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("acfc: next-cycle check failed");

`endif

@@ rtl/acfc_pkg.sv @@
// Types, constants and the CRC byte update of the frame checker.
`default_nettype none
package acfc_pkg;

    localparam logic [7:0]  STX_CODE   = 8'h02;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;
    localparam logic [7:0]  ASCII_NINE = 8'h39;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOP    = 16'h8000;
    localparam logic [7:0]  BYTE_TOP   = 8'h80;
    localparam logic [2:0]  LEN_DIGITS = 3'd4;
    localparam logic [2:0]  CRC_DIGITS = 3'd5;

    typedef enum logic [1:0] {
        V_OK        = 2'd0,
        V_NO_STX    = 2'd1,
        V_BAD_DIGIT = 2'd2,
        V_MISMATCH  = 2'd3
    } t_verdict;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_STX  = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_MSG  = 5'b01000,
        PH_CRC  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] payload_byte;
        t_verdict   verdict;
        logic [13:0] msg_length;
        logic       frame_done;
    } t_result;

    // Shift one byte into the CRC, MSB first, no augmentation.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  m;
        c = crc;
        m = BYTE_TOP;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'd0) begin
                c = {c[14:0], ((b & m) != 8'd0)} ^ CRC_POLY;
            end else begin
                c = {c[14:0], ((b & m) != 8'd0)};
            end
            m = m >> 1;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

endpackage
`default_nettype wire

@@ rtl/acfc_rx_if.sv @@
// Valid/ready channel carrying received bytes into the checker.
`default_nettype none
interface acfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface
`default_nettype wire

@@ rtl/acfc_res_if.sv @@
// Valid/ready channel carrying forwarded bytes and verdicts out of the checker.
`default_nettype none
interface acfc_res_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  verdict;
    logic [13:0] msg_length;
    logic        frame_done;

    modport source (output valid, output out_kind, output payload_byte, output verdict,
                    output msg_length, output frame_done, input ready);
    modport sink   (input valid, input out_kind, input payload_byte, input verdict,
                    input msg_length, input frame_done, output ready);
endinterface
`default_nettype wire

@@ rtl/ascii_crc_frame_checker_unit.sv @@
// Top level of the STX / ASCII length / CRC-16 reply frame checker.
//
// Usage:
//   i_rx  : one received byte per transaction, frame_start high on the first
//           byte of each reply (status byte or STX, see skip register).
//   o_res : forwarded message bytes (out_kind 0) and at most one verdict per
//           frame (out_kind 1, frame_done 1) carrying ok / missing STX / bad
//           digit / CRC mismatch and the decoded length.
//   i_cfg_we / i_cfg_wdata : skip_leading_byte, write only while idle.
// Each result is registered in the result buffer as its byte is taken.
// Throughput: one byte per cycle while i_rx.ready is high; the CRC byte
//   update and decimal digit accumulate sit in a single combinational pass
//   between the state registers and the two-entry result buffer.
// Stall: the result buffer holds two transactions, so a byte is still taken
//   while one result waits; i_rx.ready drops only when both entries are full.
// Reset: synchronous, active low; phase returns to idle, the buffer empties
//   and skip_leading_byte returns to 1.
`default_nettype none
module ascii_crc_frame_checker_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    acfc_rx_if.sink    i_rx,
    acfc_res_if.source o_res
);

    // Frame state
    acfc_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_dcnt, n_dcnt;
    logic [13:0]      r_len, n_len;
    logic [13:0]      r_left, n_left;
    logic [15:0]      r_crc, n_crc;
    logic [16:0]      r_rcrc, n_rcrc;
    acfc_pkg::t_verdict r_err, n_err;
    logic             r_skip;

    // Two-entry result buffer; entry 0 faces the output
    acfc_pkg::t_result r_slot0, n_slot0, r_slot1, n_slot1;
    logic [1:0]        r_cnt, n_cnt;

    logic              in_fire, pop, push;
    logic [1:0]        cnt_after_pop;
    acfc_pkg::t_result res;

    assign i_rx.ready = (r_cnt != 2'd2);
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign pop        = o_res.valid && o_res.ready;

    assign o_res.valid        = (r_cnt != 2'd0);
    assign o_res.out_kind     = r_slot0.out_kind;
    assign o_res.payload_byte = r_slot0.payload_byte;
    assign o_res.verdict      = r_slot0.verdict;
    assign o_res.msg_length   = r_slot0.msg_length;
    assign o_res.frame_done   = r_slot0.frame_done;

    // Frame parsing: one byte per pass
    always_comb begin
        logic [7:0]  b;
        logic [2:0]  dc_inc;
        logic [13:0] len_acc;
        logic [16:0] rc_acc;
        acfc_pkg::t_phase ph;

        b       = i_rx.rx_byte;
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_len   = r_len;
        n_left  = r_left;
        n_crc   = r_crc;
        n_rcrc  = r_rcrc;
        n_err   = r_err;
        push    = 1'b0;
        res     = '{out_kind: 1'b1, payload_byte: 8'd0, verdict: acfc_pkg::V_OK,
                    msg_length: 14'd0, frame_done: 1'b1};
        ph      = r_phase;
        dc_inc  = 3'd0;
        len_acc = 14'd0;
        rc_acc  = 17'd0;

        if (in_fire) begin
            // Restart on frame_start; the start byte itself may be a status byte
            if (i_rx.frame_start) begin
                n_dcnt  = 3'd0;
                n_len   = 14'd0;
                n_left  = 14'd0;
                n_crc   = 16'd0;
                n_rcrc  = 17'd0;
                n_err   = acfc_pkg::V_OK;
                n_phase = acfc_pkg::PH_STX;
                ph      = r_skip ? acfc_pkg::PH_IDLE : acfc_pkg::PH_STX;
            end

            dc_inc  = n_dcnt + 3'd1;
            len_acc = {n_len[10:0], 3'b000} + {n_len[12:0], 1'b0} + {10'd0, b[3:0]};
            rc_acc  = {n_rcrc[13:0], 3'b000} + {n_rcrc[15:0], 1'b0} + {13'd0, b[3:0]};

            unique case (ph)
                acfc_pkg::PH_IDLE: begin
                    // stray byte or skipped status byte: drop it
                end
                acfc_pkg::PH_STX: begin
                    if (b != acfc_pkg::STX_CODE) begin
                        push        = 1'b1;
                        res.verdict = acfc_pkg::V_NO_STX;
                        n_phase     = acfc_pkg::PH_IDLE;
                    end else begin
                        n_phase = acfc_pkg::PH_LEN;
                    end
                end
                acfc_pkg::PH_LEN: begin
                    if (!acfc_pkg::is_digit(b)) begin
                        push        = 1'b1;
                        res.verdict = acfc_pkg::V_BAD_DIGIT;
                        n_phase     = acfc_pkg::PH_IDLE;
                    end else begin
                        n_crc = acfc_pkg::crc_feed(n_crc, b);
                        n_len = len_acc;
                        if (dc_inc == acfc_pkg::LEN_DIGITS) begin
                            n_dcnt  = 3'd0;
                            n_left  = len_acc;
                            n_phase = (len_acc == 14'd0) ? acfc_pkg::PH_CRC
                                                         : acfc_pkg::PH_MSG;
                        end else begin
                            n_dcnt = dc_inc;
                        end
                    end
                end
                acfc_pkg::PH_MSG: begin
                    n_crc  = acfc_pkg::crc_feed(n_crc, b);
                    n_left = n_left - 14'd1;
                    if (n_left == 14'd0) begin
                        n_phase = acfc_pkg::PH_CRC;
                    end
                    push   = 1'b1;
                    res    = '{out_kind: 1'b0, payload_byte: b, verdict: acfc_pkg::V_OK,
                               msg_length: n_len, frame_done: 1'b0};
                end
                acfc_pkg::PH_CRC: begin
                    if (acfc_pkg::is_digit(b)) begin
                        n_rcrc = rc_acc;
                    end else begin
                        n_err = acfc_pkg::V_BAD_DIGIT;
                    end
                    if (dc_inc == acfc_pkg::CRC_DIGITS) begin
                        n_dcnt         = 3'd0;
                        push           = 1'b1;
                        res.msg_length = n_len;
                        n_phase        = acfc_pkg::PH_IDLE;
                        priority if (n_err != acfc_pkg::V_OK) begin
                            res.verdict = n_err;
                        end else if (n_rcrc[16] || (n_rcrc[15:0] != n_crc)) begin
                            res.verdict = acfc_pkg::V_MISMATCH;
                        end else begin
                            res.verdict = acfc_pkg::V_OK;
                        end
                    end else begin
                        n_dcnt = dc_inc;
                    end
                end
                default: begin
                    n_phase = acfc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result buffer: shift on pop, then fill the first free entry
    always_comb begin
        cnt_after_pop = r_cnt - {1'b0, pop};
        n_slot0       = pop ? r_slot1 : r_slot0;
        n_slot1       = r_slot1;
        if (push) begin
            if (cnt_after_pop[0]) begin
                n_slot1 = res;
            end else begin
                n_slot0 = res;
            end
        end
        n_cnt = cnt_after_pop + {1'b0, push};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= acfc_pkg::PH_IDLE;
            r_dcnt  <= 3'd0;
            r_len   <= 14'd0;
            r_left  <= 14'd0;
            r_crc   <= 16'd0;
            r_rcrc  <= 17'd0;
            r_err   <= acfc_pkg::V_OK;
            r_skip  <= 1'b1;
            r_cnt   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_dcnt  <= n_dcnt;
            r_len   <= n_len;
            r_left  <= n_left;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_skip <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule
`default_nettype wire

@@ rtl/acfc_checker.sv @@
// Port-level assertions for the frame checker, bound to its top level.
`default_nettype none
`include "ascii_crc_frame_checker_unit_defines.svh"
module acfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_kind,
    input wire logic [7:0]  i_payload_byte,
    input wire logic [1:0]  i_verdict,
    input wire logic [13:0] i_msg_length,
    input wire logic        i_frame_done
);

    // A verdict transaction carries no byte and always ends the frame
    `ACFC_ASSERT_IMP(a_verdict_shape, i_clk, !i_rst_n, i_out_valid && i_out_kind, i_payload_byte == 8'd0 && i_frame_done)

    // A forwarded byte carries no verdict and does not end the frame
    `ACFC_ASSERT_IMP(a_byte_shape, i_clk, !i_rst_n, i_out_valid && !i_out_kind, i_verdict == acfc_pkg::V_OK && !i_frame_done)

    // Missing STX is flagged before any length digit is read
    `ACFC_ASSERT_IMP(a_nostx_len, i_clk, !i_rst_n, i_out_valid && i_verdict == acfc_pkg::V_NO_STX, i_msg_length == 14'd0)

    // A stalled result holds
    `ACFC_ASSERT_NXT(a_stall_hold, i_clk, !i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_payload_byte) && $stable(i_verdict) && $stable(i_msg_length))

    // Reset empties the result buffer
    `ACFC_ASSERT_NXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !i_out_valid)

endmodule

bind ascii_crc_frame_checker_unit acfc_checker u_acfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_kind     (o_res.out_kind),
    .i_payload_byte (o_res.payload_byte),
    .i_verdict      (o_res.verdict),
    .i_msg_length   (o_res.msg_length),
    .i_frame_done   (o_res.frame_done)
);
`default_nettype wire

@@ bench/ascii_crc_frame_checker_unit_checker.sv @@
// Monitor that predicts the frame checker's output stream and compares it against the block.
`timescale 1ns / 100ps
module ascii_crc_frame_checker_unit_checker
    import acfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    acfc_rx_if   i_rx_mon,
    acfc_res_if  i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow of the block's frame state
    logic        skip_status;
    t_phase      frame_phase;
    logic [2:0]  digits_seen;
    logic [13:0] decoded_len;
    logic [13:0] remaining;
    logic [15:0] crc_acc;
    logic [16:0] crc_field;
    logic        crc_field_bad;

    t_result     results_due[$];
    int          mismatches;

    function automatic logic [15:0] crc16_shift_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15];
            acc = {acc[14:0], b[i]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic t_result close_frame(input t_verdict v, input logic [13:0] len);
        frame_phase = PH_IDLE;
        return '{out_kind: 1'b1, payload_byte: 8'h00, verdict: v, msg_length: len,
                 frame_done: 1'b1};
    endfunction

    // Advance the shadow state by one received byte; return 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, input logic st, output t_result r);
        logic     digit_ok;
        t_verdict v;
        digit_ok = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
        r = '0;
        if (st) begin
            digits_seen   = '0;
            decoded_len   = '0;
            remaining     = '0;
            crc_acc       = '0;
            crc_field     = '0;
            crc_field_bad = 1'b0;
            frame_phase   = PH_STX;
            if (skip_status) return 1'b0;
        end
        case (frame_phase)
            PH_STX: begin
                if (b != STX_CODE) begin
                    r = close_frame(V_NO_STX, 14'd0);
                    return 1'b1;
                end
                frame_phase = PH_LEN;
            end
            PH_LEN: begin
                if (!digit_ok) begin
                    r = close_frame(V_BAD_DIGIT, 14'd0);
                    return 1'b1;
                end
                crc_acc     = crc16_shift_byte(crc_acc, b);
                decoded_len = 14'(decoded_len * 10 + (b - ASCII_ZERO));
                digits_seen = digits_seen + 3'd1;
                if (digits_seen >= LEN_DIGITS) begin
                    digits_seen = '0;
                    remaining   = decoded_len;
                    frame_phase = (remaining == 14'd0) ? PH_CRC : PH_MSG;
                end
            end
            PH_MSG: begin
                crc_acc   = crc16_shift_byte(crc_acc, b);
                remaining = remaining - 14'd1;
                if (remaining == 14'd0) frame_phase = PH_CRC;
                r = '{out_kind: 1'b0, payload_byte: b, verdict: V_OK, msg_length: decoded_len,
                      frame_done: 1'b0};
                return 1'b1;
            end
            PH_CRC: begin
                if (digit_ok) crc_field = 17'(crc_field * 10 + (b - ASCII_ZERO));
                else crc_field_bad = 1'b1;
                digits_seen = digits_seen + 3'd1;
                if (digits_seen >= CRC_DIGITS) begin
                    digits_seen = '0;
                    if (crc_field_bad) v = V_BAD_DIGIT;
                    else if (crc_field != {1'b0, crc_acc}) v = V_MISMATCH;
                    else v = V_OK;
                    r = close_frame(v, decoded_len);
                    return 1'b1;
                end
            end
            default: frame_phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            skip_status   = 1'b1;
            frame_phase   = PH_IDLE;
            digits_seen   = '0;
            decoded_len   = '0;
            remaining     = '0;
            crc_acc       = '0;
            crc_field     = '0;
            crc_field_bad = 1'b0;
            results_due.delete();
            mismatches    = 0;
        end else begin
            if (i_cfg_we) skip_status = i_cfg_wdata;
            if (i_rx_mon.valid && i_rx_mon.ready) begin
                if (decode_byte(i_rx_mon.rx_byte, i_rx_mon.frame_start, want))
                    results_due.push_back(want);
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.out_kind     = i_res_mon.out_kind;
                got.payload_byte = i_res_mon.payload_byte;
                got.verdict      = t_verdict'(i_res_mon.verdict);
                got.msg_length   = i_res_mon.msg_length;
                got.frame_done   = i_res_mon.frame_done;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind=%0d byte=%02h verdict=%0d len=%0d done=%0d",
                                 got.out_kind, got.payload_byte, got.verdict, got.msg_length,
                                 got.frame_done);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind=%0d byte=%02h verdict=%0d len=%0d",
                                      " done=%0d, got kind=%0d byte=%02h verdict=%0d len=%0d",
                                      " done=%0d"},
                                     want.out_kind, want.payload_byte, want.verdict,
                                     want.msg_length, want.frame_done, got.out_kind,
                                     got.payload_byte, got.verdict, got.msg_length,
                                     got.frame_done);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= results_due.size();
    end

endmodule

@@ bench/ascii_crc_frame_checker_unit_tb.sv @@
// Stimulus, clocking and final verdict for the ASCII length / CRC-16 frame checker.
`timescale 1ns / 100ps
module ascii_crc_frame_checker_unit_tb;
    import acfc_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_GAP   = 4;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    acfc_rx_if  rx_chan();
    acfc_res_if res_chan();

    int fail_count;
    int results_pending;
    int cycle_count;

    // Idle percentages per side, and the receiver's long hold-off request
    int tx_gap_pct;
    int sink_gap_pct;
    bit hold_off_req;

    // Mirror of the skip register as last written, used to shape frames
    logic       skip_now;
    logic [7:0] frame_bytes[$];
    int         sent_items;

    ascii_crc_frame_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_chan),
        .o_res       (res_chan)
    );

    ascii_crc_frame_checker_unit_checker verdict_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx_mon     (rx_chan),
        .i_res_mon    (res_chan),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Hard stop: end the run if the block wedges or a result never turns up.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ascii_crc_frame_checker_unit verification failed");
        $finish;
    end

    // Receiver: drop ready at random, or hold it low for a long stretch on request
    // so that the two-entry result buffer fills and the input side stalls.
    initial begin
        res_chan.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_chan.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                res_chan.ready <= ($urandom_range(99) >= sink_gap_pct);
                @(posedge i_clk);
            end
        end
    end

    // Non-augmented shift: each message bit enters at the bottom of the register.
    function automatic logic [15:0] crc_shift(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] acc;
        acc = c;
        for (int i = 7; i >= 0; i--) acc = {acc[14:0], b[i]} ^ (acc[15] ? CRC_POLY : 16'h0000);
        return acc;
    endfunction

    // Append a zero-padded decimal field of the given width.
    function automatic void put_digits(input int unsigned value, input int count);
        int unsigned scale;
        scale = 1;
        for (int k = 1; k < count; k++) scale *= 10;
        for (int k = 0; k < count; k++) begin
            frame_bytes.push_back(ASCII_ZERO + 8'((value / scale) % 10));
            scale /= 10;
        end
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b >= ASCII_ZERO && b <= ASCII_NINE);
        return b;
    endfunction

    // Build a well-formed frame with a correct CRC field over the length
    // digits and the message.
    function automatic void make_frame(input int len);
        logic [15:0] crc;
        frame_bytes.delete();
        if (skip_now) frame_bytes.push_back(8'($urandom_range(255)));
        frame_bytes.push_back(STX_CODE);
        put_digits(len, 4);
        repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
        crc = '0;
        for (int k = (skip_now ? 2 : 1); k < frame_bytes.size(); k++)
            crc = crc_shift(crc, frame_bytes[k]);
        put_digits(crc, 5);
    endfunction

    // Offer one byte; hold valid high until the transaction completes.
    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < tx_gap_pct) begin
            rx_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_chan.valid       <= 1'b1;
        rx_chan.rx_byte     <= b;
        rx_chan.frame_start <= st;
        @(posedge i_clk);
        while (!rx_chan.ready) @(posedge i_clk);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_bytes.size(); k++) send_byte(frame_bytes[k], k == 0);
        sent_items += frame_bytes.size();
    endtask

    // Drop valid and wait until every predicted result has been taken, then
    // idle for a settling gap, for a frame still mid-flight without a result.
    task automatic settle_idle();
        rx_chan.valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_skip(input logic value);
        settle_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        skip_now     = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 85) return $urandom_range(12, 1);
        if (r < 97) return $urandom_range(60, 13);
        return $urandom_range(400, 200);
    endfunction

    // One random frame: mostly clean, the rest corrupted in one way each.
    task automatic send_random_frame();
        int pick;
        int stx_at;
        int pos;
        logic [7:0] b;
        pick   = $urandom_range(99);
        stx_at = skip_now ? 1 : 0;
        make_frame(pick_length());
        if (pick < 70) begin
            // clean frame, expect ok
        end else if (pick < 76) begin
            // alter one CRC digit to another digit
            pos = frame_bytes.size() - 1 - $urandom_range(4);
            frame_bytes[pos] = ASCII_ZERO
                + 8'((frame_bytes[pos] - ASCII_ZERO + 1 + $urandom_range(8)) % 10);
        end else if (pick < 80) begin
            // CRC field out of 16-bit range
            frame_bytes = frame_bytes[0:$-5];
            put_digits($urandom_range(99999, 65536), 5);
        end else if (pick < 86) begin
            pos = frame_bytes.size() - 1 - $urandom_range(4);
            frame_bytes[pos] = non_digit();
        end else if (pick < 91) begin
            // bad length digit ends the frame at once
            pos = stx_at + 1 + $urandom_range(3);
            frame_bytes[pos] = non_digit();
            frame_bytes = frame_bytes[0:pos];
        end else if (pick < 95) begin
            do b = 8'($urandom_range(255)); while (b == STX_CODE);
            frame_bytes[stx_at] = b;
            frame_bytes = frame_bytes[0:stx_at];
        end else begin
            // cut short; the next frame start drops it
            pos = $urandom_range(frame_bytes.size() - 1, 1);
            frame_bytes = frame_bytes[0:pos-1];
        end
        send_frame();
        // stray bytes between frames, normally ignored by an idle checker
        if ($urandom_range(19) == 0)
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic run_frames(input int target);
        int stop_at;
        stop_at = sent_items + target;
        while (sent_items < stop_at) send_random_frame();
    endtask

    initial begin
        rx_chan.valid       <= 1'b0;
        rx_chan.rx_byte     <= 8'h00;
        rx_chan.frame_start <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= 1'b0;
        i_rst_n             <= 1'b0;
        hold_off_req         = 1'b0;
        tx_gap_pct           = 0;
        sink_gap_pct         = 0;
        skip_now             = 1'b1;
        sent_items           = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, skip register at its reset value of 1.
        // A stray byte with no frame open is ignored.
        send_byte(8'h5A, 1'b0);
        // Wrong byte where STX belongs.
        frame_bytes = '{8'hFF, 8'h03};
        send_frame();
        // Non-digit just below '0' among the length digits.
        frame_bytes = '{8'h00, STX_CODE, ASCII_ZERO + 8'd1, ASCII_ZERO - 8'd1};
        send_frame();
        // Largest length, message bytes at both extremes, then cut off by the
        // next frame start.
        frame_bytes = '{8'h80, STX_CODE, ASCII_NINE, ASCII_NINE, ASCII_NINE, ASCII_NINE,
                        8'h00, 8'hFF};
        send_frame();
        // Zero length with a non-digit just above '9' as the last CRC digit.
        make_frame(0);
        frame_bytes[$] = ASCII_NINE + 8'd1;
        send_frame();

        // Sender idles more lightly than the receiver.
        tx_gap_pct   = 21;
        sink_gap_pct = 49;
        write_skip(1'b0);
        run_frames(600);

        // And the other way round.
        tx_gap_pct   = 49;
        sink_gap_pct = 21;
        write_skip(1'b1);
        run_frames(600);

        // Full rate on both sides.
        tx_gap_pct   = 0;
        sink_gap_pct = 0;
        write_skip(1'b0);
        // Hold the receiver off while a long clean frame streams in, so the
        // result buffer fills and input transactions stall; then pause the
        // sender until every result has drained.
        hold_off_req = 1'b1;
        make_frame(40);
        send_frame();
        settle_idle();
        run_frames(300);
        write_skip(1'b1);
        run_frames(300);

        settle_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("ascii_crc_frame_checker_unit verification clean");
        end else begin
            $display("ascii_crc_frame_checker_unit verification failed");
        end
        $finish;
    end

endmodule
